// ===== src/detection_decode_and_nms_macros.svh =====
// Assertion macros used by the detection decoder top level.
`ifndef DETECTION_DECODE_AND_NMS_MACROS_SVH
`define DETECTION_DECODE_AND_NMS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DDN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DDN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ddn_pkg.sv =====
// Package with constants, types and register codes of the detection decoder.
`default_nettype none
package ddn_pkg;

  localparam int MAX_CANDIDATES = 1024;
  localparam int CAND_AW        = $clog2(MAX_CANDIDATES);
  localparam int CNT_W          = CAND_AW + 1;
  localparam int MAX_CLASSES    = 128;
  localparam int MAX_KEPT       = 64;
  localparam int KEPT_AW        = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int KEPT_CNT_W     = $clog2(MAX_KEPT + 1);
  localparam logic [12:0] ONE_Q12 = 13'd4096;

  typedef enum logic [2:0] {
    REG_CONF_THR    = 3'd0,
    REG_OVL_THR     = 3'd1,
    REG_CLASS_COUNT = 3'd2,
    REG_HAS_OBJ     = 3'd3,
    REG_MAX_DET     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [12:0] conf_thr;
    logic [12:0] ovl_thr;
    logic [7:0]  ncls;
    logic        has_obj;
    logic [6:0]  limit;
  } cfg_t;

  typedef struct packed {
    logic [6:0]         cls;
    logic [12:0]        conf;
    logic signed [23:0] left;
    logic signed [23:0] top;
    logic [22:0]        w;
    logic [22:0]        h;
  } cand_t;

  typedef struct packed {
    cand_t       c;
    logic [45:0] area;
  } kept_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             overflow;
    logic             busy;
  } dec_stat_t;

  typedef struct packed {
    logic               valid_res;
    logic [6:0]         class_id;
    logic [12:0]        confidence;
    logic signed [23:0] box_left;
    logic signed [23:0] box_top;
    logic [22:0]        box_width;
    logic [22:0]        box_height;
    logic               store_overflow;
    logic               last;
  } out_t;

endpackage
`default_nettype wire

// ===== src/ddn_if.sv =====
// Handshake interfaces for the attribute input and the detection output.
`default_nettype none
interface ddn_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] attribute_value;
  logic               end_of_frame;
  modport source (output valid, attribute_value, end_of_frame, input ready);
  modport sink (input valid, attribute_value, end_of_frame, output ready);
endinterface

interface ddn_out_if;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic [6:0]         class_id;
  logic [12:0]        confidence;
  logic signed [23:0] box_left;
  logic signed [23:0] box_top;
  logic [22:0]        box_width;
  logic [22:0]        box_height;
  logic               store_overflow;
  logic               last;
  modport source (output valid, valid_res, class_id, confidence, box_left, box_top,
                  box_width, box_height, store_overflow, last, input ready);
  modport sink (input valid, valid_res, class_id, confidence, box_left, box_top,
                box_width, box_height, store_overflow, last, output ready);
endinterface
`default_nettype wire

// ===== src/ddn_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module ddn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/ddn_decode.sv =====
// Attribute decoder: box capture, class argmax, confidence and candidate store writes.
`default_nettype none
module ddn_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_accept_i,
  input  logic signed [23:0]            value_i,
  input  logic                          eof_i,
  input  ddn_pkg::cfg_t                 cfg_i,
  input  logic                          frame_clear_i,
  output logic                          cand_we_o,
  output logic [ddn_pkg::CAND_AW-1:0]   cand_waddr_o,
  output ddn_pkg::cand_t                cand_wdata_o,
  output ddn_pkg::dec_stat_t            stat_o
);
  import ddn_pkg::*;

  logic [7:0]         idx_q;
  logic signed [23:0] fld_q [5];
  logic signed [23:0] fld_new [5];
  logic               best_valid_q, best_valid_new;
  logic [6:0]         best_cls_q, best_cls_new;
  logic signed [23:0] best_score_q, best_score_new;
  logic [7:0]         last_idx, cls_idx;
  logic               finish;

  logic               s1_v_q, s1_bv_q;
  logic signed [23:0] s1_x_q, s1_y_q, s1_w_q, s1_h_q, s1_obj_q, s1_score_q;
  logic [6:0]         s1_cls_q;

  logic               s2_v_q, s2_drop_q;
  logic signed [47:0] s2_prod_q;
  logic signed [23:0] s2_left_q, s2_top_q;
  logic [22:0]        s2_w_q, s2_h_q;
  logic [6:0]         s2_cls_q;

  logic [CNT_W-1:0]   cnt_q;
  logic               ovf_q;
  logic [33:0]        conf_raw;
  logic [12:0]        conf_sat;
  logic               keep, full;

  function automatic logic signed [23:0] corner(logic signed [23:0] c, logic signed [23:0] s);
    logic signed [24:0] d;
    d = {c[23], c} - {3'b000, s[22:1]};
    if (d > 25'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (d < -25'sd8388608) begin
      return 24'sh800000;
    end else begin
      return d[23:0];
    end
  endfunction

  always_comb begin
    last_idx = 8'd3 + {7'd0, cfg_i.has_obj} + cfg_i.ncls;
    cls_idx  = idx_q - 8'd4 - {7'd0, cfg_i.has_obj};
    for (int k = 0; k < 5; k++) begin
      fld_new[k] = fld_q[k];
    end
    best_valid_new = best_valid_q;
    best_cls_new   = best_cls_q;
    best_score_new = best_score_q;
    if (idx_q < 8'd4) begin
      fld_new[idx_q[1:0]] = value_i;
    end else if (cfg_i.has_obj && idx_q == 8'd4) begin
      fld_new[4] = value_i;
    end else if (cls_idx < cfg_i.ncls && value_i > best_score_q) begin
      best_valid_new = 1'b1;
      best_cls_new   = cls_idx[6:0];
      best_score_new = value_i;
    end
    finish = idx_q >= last_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      best_valid_q <= 1'b0;
      best_cls_q   <= '0;
      best_score_q <= '0;
      for (int k = 0; k < 5; k++) begin
        fld_q[k] <= '0;
      end
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_accept_i && finish;
      s2_v_q <= s1_v_q;
      if (in_accept_i) begin
        for (int k = 0; k < 5; k++) begin
          fld_q[k] <= fld_new[k];
        end
        if (finish || eof_i) begin
          idx_q        <= '0;
          best_valid_q <= 1'b0;
          best_cls_q   <= '0;
          best_score_q <= '0;
        end else begin
          idx_q        <= idx_q + 8'd1;
          best_valid_q <= best_valid_new;
          best_cls_q   <= best_cls_new;
          best_score_q <= best_score_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i && finish) begin
      s1_x_q     <= fld_new[0];
      s1_y_q     <= fld_new[1];
      s1_w_q     <= fld_new[2];
      s1_h_q     <= fld_new[3];
      s1_obj_q   <= cfg_i.has_obj ? fld_new[4] : 24'sd4096;
      s1_cls_q   <= best_cls_new;
      s1_score_q <= best_score_new;
      s1_bv_q    <= best_valid_new;
    end
    s2_prod_q <= s1_obj_q * s1_score_q;
    s2_drop_q <= (s1_w_q <= 24'sd0) || (s1_h_q <= 24'sd0) || !s1_bv_q;
    s2_left_q <= corner(s1_x_q, s1_w_q);
    s2_top_q  <= corner(s1_y_q, s1_h_q);
    s2_w_q    <= s1_w_q[22:0];
    s2_h_q    <= s1_h_q[22:0];
    s2_cls_q  <= s1_cls_q;
  end

  always_comb begin
    conf_raw = s2_prod_q[45:12];
    conf_sat = (conf_raw > 34'd4096) ? ONE_Q12 : conf_raw[12:0];
    keep     = s2_v_q && !s2_drop_q && !s2_prod_q[47] && (conf_sat >= cfg_i.conf_thr);
    full     = cnt_q >= CNT_W'(MAX_CANDIDATES);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (frame_clear_i) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (keep) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign cand_we_o         = keep && !full;
  assign cand_waddr_o      = cnt_q[CAND_AW-1:0];
  assign cand_wdata_o.cls  = s2_cls_q;
  assign cand_wdata_o.conf = conf_sat;
  assign cand_wdata_o.left = s2_left_q;
  assign cand_wdata_o.top  = s2_top_q;
  assign cand_wdata_o.w    = s2_w_q;
  assign cand_wdata_o.h    = s2_h_q;
  assign stat_o.cnt        = cnt_q;
  assign stat_o.overflow   = ovf_q;
  assign stat_o.busy       = s1_v_q || s2_v_q;
endmodule
`default_nettype wire

// ===== src/ddn_nms.sv =====
// Frame sequencer: confidence-ordered selection, same-class suppression and result output.
`default_nettype none
module ddn_nms (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        eof_i,
  output logic                        in_ready_o,
  input  ddn_pkg::cfg_t               cfg_i,
  input  ddn_pkg::dec_stat_t          stat_i,
  output logic                        frame_clear_o,
  output logic [ddn_pkg::CAND_AW-1:0] cand_raddr_o,
  input  ddn_pkg::cand_t              cand_rdata_i,
  ddn_out_if.source                   out_o
);
  import ddn_pkg::*;

  typedef enum logic [3:0] {
    ST_STREAM, ST_DRAIN, ST_SCAN, ST_AREA, ST_KRD, ST_KGEO, ST_KMUL, ST_KUNI, ST_KCMP,
    ST_OSTART, ST_ORD, ST_OLD, ST_OWAIT
  } state_e;

  state_e                state_q;
  logic [CNT_W-1:0]      scan_addr_q;
  logic                  pend_q, found_q, have_last_q;
  logic [CAND_AW-1:0]    pidx_q, best_idx_q, last_idx_q;
  logic [12:0]           last_conf_q;
  cand_t                 best_q;
  logic [45:0]           area_q, karea_q;
  logic [KEPT_CNT_W-1:0] kept_cnt_q, j_q;
  logic [24:0]           iw_q, ih_q;
  logic [49:0]           inter_q;
  logic [47:0]           uni_q;
  out_t                  out_q;
  logic                  out_valid_q;

  kept_t                 kd, kwdata;
  logic                  kwe;
  logic [KEPT_AW-1:0]    kwaddr, kraddr;
  logic                  elig, better;
  logic signed [23:0]    l, t;
  logic signed [24:0]    r1, r2, b1, b2, r, b;
  logic signed [25:0]    dx, dy;
  logic [24:0]           iw, ih;
  logic [61:0]           lhs, rhs;
  logic                  sup;

  always_comb begin
    elig = !have_last_q || (cand_rdata_i.conf < last_conf_q) ||
           ((cand_rdata_i.conf == last_conf_q) && (pidx_q > last_idx_q));
    better = elig && (!found_q || (cand_rdata_i.conf > best_q.conf));

    l  = (kd.c.left > best_q.left) ? kd.c.left : best_q.left;
    t  = (kd.c.top > best_q.top) ? kd.c.top : best_q.top;
    r1 = {kd.c.left[23], kd.c.left} + {2'b00, kd.c.w};
    r2 = {best_q.left[23], best_q.left} + {2'b00, best_q.w};
    b1 = {kd.c.top[23], kd.c.top} + {2'b00, kd.c.h};
    b2 = {best_q.top[23], best_q.top} + {2'b00, best_q.h};
    r  = (r1 < r2) ? r1 : r2;
    b  = (b1 < b2) ? b1 : b2;
    dx = {r[24], r} - {l[23], l[23], l};
    dy = {b[24], b} - {t[23], t[23], t};
    iw = (dx > 26'sd0) ? dx[24:0] : '0;
    ih = (dy > 26'sd0) ? dy[24:0] : '0;

    lhs = {inter_q, 12'd0};
    rhs = 62'(cfg_i.ovl_thr * uni_q);
    sup = (uni_q != '0) && (lhs > rhs);

    kwe         = (state_q == ST_KRD) && (j_q == kept_cnt_q);
    kwaddr      = kept_cnt_q[KEPT_AW-1:0];
    kwdata.c    = best_q;
    kwdata.area = area_q;
    kraddr      = j_q[KEPT_AW-1:0];
  end

  ddn_ram #(
    .WIDTH($bits(kept_t)),
    .DEPTH(MAX_KEPT)
  ) u_kept_ram (
    .clk_i   (clk_i),
    .we_i    (kwe),
    .waddr_i (kwaddr),
    .wdata_i (kwdata),
    .raddr_i (kraddr),
    .rdata_o (kd)
  );

  assign cand_raddr_o  = scan_addr_q[CAND_AW-1:0];
  assign in_ready_o    = (state_q == ST_STREAM);
  assign frame_clear_o = (state_q == ST_OWAIT) && out_o.ready && out_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_STREAM;
      scan_addr_q <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      have_last_q <= 1'b0;
      kept_cnt_q  <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_STREAM: begin
          if (in_valid_i && eof_i) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!stat_i.busy) begin
            scan_addr_q <= '0;
            pend_q      <= 1'b0;
            found_q     <= 1'b0;
            state_q     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (pend_q && better) begin
            found_q    <= 1'b1;
            best_q     <= cand_rdata_i;
            best_idx_q <= pidx_q;
          end
          if (scan_addr_q < stat_i.cnt) begin
            pend_q      <= 1'b1;
            pidx_q      <= scan_addr_q[CAND_AW-1:0];
            scan_addr_q <= scan_addr_q + 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              if (found_q) begin
                have_last_q <= 1'b1;
                last_conf_q <= best_q.conf;
                last_idx_q  <= best_idx_q;
                state_q     <= ST_AREA;
              end else begin
                state_q <= ST_OSTART;
              end
            end
          end
        end
        ST_AREA: begin
          area_q  <= best_q.w * best_q.h;
          j_q     <= '0;
          state_q <= ST_KRD;
        end
        ST_KRD: begin
          if (j_q == kept_cnt_q) begin
            kept_cnt_q <= kept_cnt_q + 1'b1;
            if ((kept_cnt_q + 1'b1) == KEPT_CNT_W'(cfg_i.limit)) begin
              state_q <= ST_OSTART;
            end else begin
              scan_addr_q <= '0;
              pend_q      <= 1'b0;
              found_q     <= 1'b0;
              state_q     <= ST_SCAN;
            end
          end else begin
            state_q <= ST_KGEO;
          end
        end
        ST_KGEO: begin
          if (kd.c.cls != best_q.cls) begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_KRD;
          end else begin
            iw_q    <= iw;
            ih_q    <= ih;
            karea_q <= kd.area;
            state_q <= ST_KMUL;
          end
        end
        ST_KMUL: begin
          inter_q <= iw_q * ih_q;
          state_q <= ST_KUNI;
        end
        ST_KUNI: begin
          uni_q   <= 48'(50'(karea_q) + 50'(area_q) - inter_q);
          state_q <= ST_KCMP;
        end
        ST_KCMP: begin
          if (sup) begin
            scan_addr_q <= '0;
            pend_q      <= 1'b0;
            found_q     <= 1'b0;
            state_q     <= ST_SCAN;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_KRD;
          end
        end
        ST_OSTART: begin
          j_q <= '0;
          if (kept_cnt_q == '0) begin
            out_q       <= '{valid_res: 1'b0, class_id: '0, confidence: '0,
                             box_left: '0, box_top: '0, box_width: '0, box_height: '0,
                             store_overflow: stat_i.overflow, last: 1'b1};
            out_valid_q <= 1'b1;
            state_q     <= ST_OWAIT;
          end else begin
            state_q <= ST_ORD;
          end
        end
        ST_ORD: begin
          state_q <= ST_OLD;
        end
        ST_OLD: begin
          out_q       <= '{valid_res: 1'b1, class_id: kd.c.cls, confidence: kd.c.conf,
                           box_left: kd.c.left, box_top: kd.c.top, box_width: kd.c.w,
                           box_height: kd.c.h, store_overflow: stat_i.overflow,
                           last: ((j_q + 1'b1) == kept_cnt_q)};
          out_valid_q <= 1'b1;
          state_q     <= ST_OWAIT;
        end
        ST_OWAIT: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
            if (out_q.last) begin
              kept_cnt_q  <= '0;
              have_last_q <= 1'b0;
              state_q     <= ST_STREAM;
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= ST_ORD;
            end
          end
        end
        default: state_q <= ST_STREAM;
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.valid_res      = out_q.valid_res;
  assign out_o.class_id       = out_q.class_id;
  assign out_o.confidence     = out_q.confidence;
  assign out_o.box_left       = out_q.box_left;
  assign out_o.box_top        = out_q.box_top;
  assign out_o.box_width      = out_q.box_width;
  assign out_o.box_height     = out_q.box_height;
  assign out_o.store_overflow = out_q.store_overflow;
  assign out_o.last           = out_q.last;
endmodule
`default_nettype wire

// ===== src/detection_decode_and_nms.sv =====
// Top level of the detection decoder with class-aware non-maximum suppression.
// Usage:
// The input channel carries one attribute value per item, candidate after candidate:
// centre x, centre y, width, height, optional objectness, then the class scores.
// end_of_frame marks the last item of a frame. While a frame streams in, one item is
// taken every cycle; kept candidates are written to the candidate store memory.
// After end_of_frame, input ready stays low until the whole frame result is delivered.
// The frame phase first drains the decode stages, then repeats a selection pass over
// the store for each chosen box, followed by an overlap check against each earlier
// kept box of the same class. Results are sent one at a time; each result is held on
// the output until the receiver takes it, and the next is not prepared before then.
// An empty frame yields one marker result with valid_res low and last high.
// Configuration writes take effect at the next edge and belong between frames.
// Reset restores the register defaults and empties the store; no clearing pass is needed.
`default_nettype none
`include "detection_decode_and_nms_macros.svh"
module detection_decode_and_nms (
  input  logic        clk_i,
  input  logic        rst_ni,
  ddn_in_if.sink      in_i,
  ddn_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i
);
  import ddn_pkg::*;

  logic [12:0]        conf_thr_q, ovl_thr_q;
  logic [7:0]         class_count_q;
  logic               has_obj_q;
  logic [6:0]         max_det_q;
  cfg_t               cfg;
  dec_stat_t          stat;
  logic               frame_clear, in_accept;
  logic               cand_we;
  logic [CAND_AW-1:0] cand_waddr, cand_raddr;
  cand_t              cand_wdata, cand_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_thr_q    <= 13'd1024;
      ovl_thr_q     <= 13'd1843;
      class_count_q <= 8'd80;
      has_obj_q     <= 1'b0;
      max_det_q     <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CONF_THR:    conf_thr_q    <= cfg_data_i;
        REG_OVL_THR:     ovl_thr_q     <= cfg_data_i;
        REG_CLASS_COUNT: class_count_q <= cfg_data_i[7:0];
        REG_HAS_OBJ:     has_obj_q     <= cfg_data_i[0];
        REG_MAX_DET:     max_det_q     <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.conf_thr = (conf_thr_q > ONE_Q12) ? ONE_Q12 : conf_thr_q;
    cfg.ovl_thr  = (ovl_thr_q > ONE_Q12) ? ONE_Q12 : ovl_thr_q;
    cfg.ncls     = (int'(class_count_q) > MAX_CLASSES) ? 8'(MAX_CLASSES) : class_count_q;
    cfg.has_obj  = has_obj_q;
    if (max_det_q == 7'd0) begin
      cfg.limit = 7'd1;
    end else if (int'(max_det_q) > MAX_KEPT) begin
      cfg.limit = 7'(MAX_KEPT);
    end else begin
      cfg.limit = max_det_q;
    end
  end

  assign in_accept = in_i.valid && in_i.ready;

  ddn_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_accept_i   (in_accept),
    .value_i       (in_i.attribute_value),
    .eof_i         (in_i.end_of_frame),
    .cfg_i         (cfg),
    .frame_clear_i (frame_clear),
    .cand_we_o     (cand_we),
    .cand_waddr_o  (cand_waddr),
    .cand_wdata_o  (cand_wdata),
    .stat_o        (stat)
  );

  ddn_ram #(
    .WIDTH($bits(cand_t)),
    .DEPTH(MAX_CANDIDATES)
  ) u_cand_ram (
    .clk_i   (clk_i),
    .we_i    (cand_we),
    .waddr_i (cand_waddr),
    .wdata_i (cand_wdata),
    .raddr_i (cand_raddr),
    .rdata_o (cand_rdata)
  );

  ddn_nms u_nms (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .eof_i         (in_i.end_of_frame),
    .in_ready_o    (in_i.ready),
    .cfg_i         (cfg),
    .stat_i        (stat),
    .frame_clear_o (frame_clear),
    .cand_raddr_o  (cand_raddr),
    .cand_rdata_i  (cand_rdata),
    .out_o         (out_o)
  );

  `DDN_ASSERT_IMPL(a_ready_excl_out, in_i.ready, !out_o.valid, "input open while result pending")
  `DDN_ASSERT_IMPL(a_marker_last, out_o.valid && !out_o.valid_res, out_o.last, "marker not last")
  `DDN_ASSERT_IMPL(a_cnt_bound, 1'b1, stat.cnt <= CNT_W'(MAX_CANDIDATES), "store count overrun")
  `DDN_ASSERT_NEXT(a_frame_reopen, out_o.valid && out_o.ready && out_o.last, in_i.ready, "input not reopened")
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench of the detection decoder with class-aware non-maximum suppression.
`default_nettype none
module testbench;
  import ddn_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;

  typedef struct {
    bit                 is_cfg;
    reg_idx_e           idx;
    int                 data;
    logic signed [23:0] val;
    bit                 eof;
    bit                 has_exp;
    out_t               exp;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic        cfg_we;
  reg_idx_e    cfg_idx;
  logic [12:0] cfg_data;

  ddn_in_if  in_bus ();
  ddn_out_if out_bus ();

  detection_decode_and_nms DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Shadow copy of the registers.
  int unsigned conf_thr = 1024;
  int unsigned ovl_thr  = 1843;
  int unsigned ncls_reg = 80;
  int unsigned obj_reg  = 0;
  int unsigned maxdet   = 64;

  // Shadow copy of the decode state and the candidate store.
  longint      box_field [5];
  int          attr_idx  = 0;
  bit          best_ok   = 0;
  int          best_cls  = 0;
  longint      best_score = 0;
  longint      st_left [MAX_CANDIDATES];
  longint      st_top  [MAX_CANDIDATES];
  longint      st_w    [MAX_CANDIDATES];
  longint      st_h    [MAX_CANDIDATES];
  int          st_cls  [MAX_CANDIDATES];
  int          st_conf [MAX_CANDIDATES];
  int          st_count = 0;
  bit          st_overflow = 0;

  out_t        detections_due [$];
  int          fails = 0;
  int          items_sent = 0;
  int          cycles = 0;
  bit          calm = 0;
  bit          hold_armed = 0;
  int          hold_left = 0;
  stim_row_t   stim_rows [$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_register(input reg_idx_e idx, input int data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data[12:0];
    case (idx)
      REG_CONF_THR:    conf_thr = data & 32'h1FFF;
      REG_OVL_THR:     ovl_thr  = data & 32'h1FFF;
      REG_CLASS_COUNT: ncls_reg = data & 32'hFF;
      REG_HAS_OBJ:     obj_reg  = data & 32'h1;
      REG_MAX_DET:     maxdet   = data & 32'h7F;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Advances the shadow state by one attribute and queues the detections of a closed frame.
  task automatic absorb_attribute(input logic signed [23:0] v, input bit eof);
    longint val, w, h, obj, prod, conf;
    longint l, t, r, b;
    longint unsigned iw, ih, inter, uni;
    int ncls, has_obj, last_idx, cls, lim, thr, x, j, c, k, nkept;
    int order [MAX_CANDIDATES];
    int kept [MAX_KEPT];
    bit sup;
    out_t o;
    val = v;
    ncls = ncls_reg > MAX_CLASSES ? MAX_CLASSES : ncls_reg;
    has_obj = obj_reg;
    last_idx = 3 + has_obj + ncls;
    if (attr_idx < 4) begin
      box_field[attr_idx] = val;
    end else if (has_obj != 0 && attr_idx == 4) begin
      box_field[4] = val;
    end else begin
      cls = attr_idx - 4 - has_obj;
      if (cls < ncls && val > best_score) begin
        best_score = val;
        best_cls = cls;
        best_ok = 1;
      end
    end
    if (attr_idx >= last_idx) begin
      w = box_field[2];
      h = box_field[3];
      obj = has_obj != 0 ? box_field[4] : 4096;
      prod = obj * best_score;
      conf = prod >>> 12;
      if (conf > 4096) conf = 4096;
      if (w > 0 && h > 0 && best_ok && prod >= 0 &&
          conf >= (conf_thr > 4096 ? 4096 : conf_thr)) begin
        if (st_count >= MAX_CANDIDATES) begin
          st_overflow = 1;
        end else begin
          l = box_field[0] - (w >>> 1);
          t = box_field[1] - (h >>> 1);
          st_left[st_count] = l < -8388608 ? -8388608 : (l > 8388607 ? 8388607 : l);
          st_top[st_count]  = t < -8388608 ? -8388608 : (t > 8388607 ? 8388607 : t);
          st_w[st_count] = w;
          st_h[st_count] = h;
          st_cls[st_count] = best_cls;
          st_conf[st_count] = int'(conf);
          st_count++;
        end
      end
      attr_idx = 0;
      best_ok = 0;
      best_cls = 0;
      best_score = 0;
    end else begin
      attr_idx++;
    end
    if (!eof) return;

    lim = maxdet == 0 ? 1 : (maxdet > MAX_KEPT ? MAX_KEPT : maxdet);
    thr = ovl_thr > 4096 ? 4096 : ovl_thr;
    for (int i = 0; i < st_count; i++) begin
      x = i;
      j = i;
      while (j > 0 && st_conf[order[j-1]] < st_conf[x]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = x;
    end
    nkept = 0;
    for (int i = 0; i < st_count && nkept < lim; i++) begin
      c = order[i];
      sup = 0;
      for (j = 0; j < nkept && !sup; j++) begin
        k = kept[j];
        if (st_cls[k] == st_cls[c]) begin
          l = st_left[k] > st_left[c] ? st_left[k] : st_left[c];
          t = st_top[k] > st_top[c] ? st_top[k] : st_top[c];
          r = (st_left[k] + st_w[k]) < (st_left[c] + st_w[c]) ?
              (st_left[k] + st_w[k]) : (st_left[c] + st_w[c]);
          b = (st_top[k] + st_h[k]) < (st_top[c] + st_h[c]) ?
              (st_top[k] + st_h[k]) : (st_top[c] + st_h[c]);
          iw = r > l ? r - l : 0;
          ih = b > t ? b - t : 0;
          inter = iw * ih;
          uni = st_w[k] * st_h[k] + st_w[c] * st_h[c] - inter;
          if (uni != 0 && inter * 4096 > thr * uni) sup = 1;
        end
      end
      if (!sup) kept[nkept++] = c;
    end
    if (nkept == 0) begin
      o = '0;
      o.store_overflow = st_overflow;
      o.last = 1'b1;
      detections_due.insert(detections_due.size(), o);
    end else begin
      for (int i = 0; i < nkept; i++) begin
        c = kept[i];
        o.valid_res = 1'b1;
        o.class_id = 7'(st_cls[c]);
        o.confidence = 13'(st_conf[c]);
        o.box_left = 24'(st_left[c]);
        o.box_top = 24'(st_top[c]);
        o.box_width = 23'(st_w[c]);
        o.box_height = 23'(st_h[c]);
        o.store_overflow = st_overflow;
        o.last = (i + 1 == nkept);
        detections_due.insert(detections_due.size(), o);
      end
    end
    st_count = 0;
    st_overflow = 0;
    attr_idx = 0;
    best_ok = 0;
    best_cls = 0;
    best_score = 0;
  endtask

  task automatic send_attribute(input logic signed [23:0] v, input bit eof);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(99) < 21) begin
        in_bus.valid <= 1'b0;
      end else begin
        in_bus.valid <= 1'b1;
        in_bus.attribute_value <= v;
        in_bus.end_of_frame <= eof;
        break;
      end
    end
    do @(posedge clk_i); while (!in_bus.ready);
    absorb_attribute(v, eof);
    items_sent++;
  endtask

  // Lowers valid, waits for every pending detection and lets the block settle.
  task automatic drain;
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (detections_due.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic send_random_frame;
    logic signed [23:0] vals [$];
    int ncls, ncand, clen, cut;
    ncls = ncls_reg > MAX_CLASSES ? MAX_CLASSES : ncls_reg;
    clen = 4 + obj_reg + ncls;
    ncand = ncls > 8 ? 1 : $urandom_range(1, 6);
    for (int n = 0; n < ncand; n++) begin
      vals.insert(vals.size(), 24'($urandom_range(0, 24576)));
      vals.insert(vals.size(), 24'($urandom_range(0, 24576)));
      for (int s = 0; s < 2; s++) begin
        if ($urandom_range(99) < 6) vals.insert(vals.size(), 24'(-$urandom_range(0, 4096)));
        else vals.insert(vals.size(), 24'($urandom_range(1024, 16384)));
      end
      if (obj_reg != 0) begin
        if ($urandom_range(99) < 10) vals.insert(vals.size(), 24'(-$urandom_range(1, 8192)));
        else vals.insert(vals.size(), 24'($urandom_range(2048, 8191)));
      end
      for (int s = 0; s < ncls; s++) begin
        case ($urandom_range(9))
          0: vals.insert(vals.size(), 24'($urandom()));
          1: vals.insert(vals.size(), 24'(-$urandom_range(0, 4096)));
          2: vals.insert(vals.size(), 24'(1024 * $urandom_range(1, 4)));
          default: vals.insert(vals.size(), 24'($urandom_range(0, 4600)));
        endcase
      end
    end
    if ($urandom_range(99) < 12) begin
      cut = $urandom_range(1, clen - 1);
      while (cut-- > 0 && vals.size() > 1) void'(vals.pop_back());
    end
    for (int i = 0; i < vals.size(); i++) begin
      if ($urandom_range(99) < 3) vals[i] = 24'($urandom());
      send_attribute(vals[i], i == vals.size() - 1);
    end
  endtask

  task automatic add_cfg(input reg_idx_e idx, input int data);
    stim_row_t r;
    r = '{idx: REG_CONF_THR, default: 0};
    r.is_cfg = 1;
    r.idx = idx;
    r.data = data;
    stim_rows.insert(stim_rows.size(), r);
  endtask

  task automatic add_item(input int v, input bit eof);
    stim_row_t r;
    r = '{idx: REG_CONF_THR, default: 0};
    r.val = 24'(v);
    r.eof = eof;
    stim_rows.insert(stim_rows.size(), r);
  endtask

  task automatic check_field(input string name, input logic [23:0] e, input logic [23:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      fails++;
    end
  endtask

  // Receiver: random stalls, plus one long hold-off once armed.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (hold_armed && out_bus.valid) begin
        hold_armed = 0;
        hold_left = 400;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= calm || $urandom_range(99) >= 21;
      end
    end
  end

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (detections_due.size() == 0) begin
        $error("unexpected detection item");
        fails++;
      end else begin
        e = detections_due.pop_front();
        check_field("valid_res", e.valid_res, out_bus.valid_res);
        check_field("class_id", e.class_id, out_bus.class_id);
        check_field("confidence", e.confidence, out_bus.confidence);
        check_field("box_left", e.box_left, out_bus.box_left);
        check_field("box_top", e.box_top, out_bus.box_top);
        check_field("box_width", e.box_width, out_bus.box_width);
        check_field("box_height", e.box_height, out_bus.box_height);
        check_field("store_overflow", e.store_overflow, out_bus.store_overflow);
        check_field("last", e.last, out_bus.last);
      end
    end
  end

  initial begin
    int conf_pick [6] = '{0, 4096, 8191, 1, 2000, 0};
    int ovl_pick  [6] = '{0, 4096, 8191, 1843, 1, 3000};
    int ncls_pick [6] = '{1, 3, 0, 255, 2, 4};
    int obj_pick  [6] = '{0, 1, 0, 1, 1, 0};
    int det_pick  [6] = '{1, 127, 0, 64, 2, 5};
    int phase;
    out_t mark;

    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_CONF_THR;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.attribute_value = '0;
    in_bus.end_of_frame = 1'b0;
    for (int i = 0; i < 5; i++) box_field[i] = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: a lone partial candidate right after reset, then a saturating
    // candidate at the field extremes, then a frame of dropped candidates.
    add_item(0, 1);
    stim_rows[$].has_exp = 1;
    mark = '0;
    mark.last = 1'b1;
    stim_rows[$].exp = mark;
    add_cfg(REG_CLASS_COUNT, 2);
    add_cfg(REG_HAS_OBJ, 1);
    add_cfg(REG_CONF_THR, 0);
    add_item(8388607, 0);
    add_item(-8388608, 0);
    add_item(8388607, 0);
    add_item(1, 0);
    add_item(8388607, 0);
    add_item(8388607, 0);
    add_item(8388607, 1);
    stim_rows[$].has_exp = 1;
    stim_rows[$].exp = '{valid_res: 1'b1, class_id: 7'd0, confidence: 13'd4096,
                         box_left: 24'sd4194304, box_top: 24'sh800000,
                         box_width: 23'd8388607, box_height: 23'd1,
                         store_overflow: 1'b0, last: 1'b1};
    add_item(0, 0);
    add_item(0, 0);
    add_item(4096, 0);
    add_item(4096, 0);
    add_item(-4096, 0);
    add_item(4096, 0);
    add_item(10, 0);
    add_item(0, 0);
    add_item(0, 0);
    add_item(0, 0);
    add_item(4096, 0);
    add_item(4096, 0);
    add_item(100, 0);
    add_item(-1, 1);
    stim_rows[$].has_exp = 1;
    stim_rows[$].exp = mark;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        drain();
        write_register(stim_rows[i].idx, stim_rows[i].data);
      end else begin
        send_attribute(stim_rows[i].val, stim_rows[i].eof);
        if (stim_rows[i].has_exp) begin
          void'(detections_due.pop_back());
          detections_due.insert(detections_due.size(), stim_rows[i].exp);
        end
      end
    end

    // Random part, one register setting per phase.
    phase = 0;
    while ((phase < 6 || items_sent < 360) && phase < 300) begin
      drain();
      if (phase == 0) hold_armed = 1;
      calm = (phase == 4 || phase == 5);
      if (phase < 6) begin
        write_register(REG_CONF_THR, conf_pick[phase]);
        write_register(REG_OVL_THR, ovl_pick[phase]);
        write_register(REG_CLASS_COUNT, ncls_pick[phase]);
        write_register(REG_HAS_OBJ, obj_pick[phase]);
        write_register(REG_MAX_DET, det_pick[phase]);
      end else begin
        write_register(REG_CONF_THR, $urandom_range(0, 3000));
        write_register(REG_OVL_THR, $urandom_range(0, 9) == 0 ? 8191 : $urandom_range(0, 4096));
        write_register(REG_CLASS_COUNT, $urandom_range(1, 6));
        write_register(REG_HAS_OBJ, $urandom_range(0, 1));
        write_register(REG_MAX_DET, $urandom_range(0, 3) == 0 ? 64 : $urandom_range(1, 20));
      end
      repeat (phase == 0 ? 2 : (ncls_reg > 8 ? 1 : $urandom_range(1, 3))) send_random_frame();
      phase++;
    end
    calm = 0;

    drain();
    repeat (40) @(posedge clk_i);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
